[hw/rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg: shared definitions for the sphere collision projector
// Defaults, field widths, input mode codes, register indexes and item kinds.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int RADIUS_W        = 31;
  localparam int DELTA_W         = 16;
  localparam int MODE_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH     = 2;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POINT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd6;

  // work kinds handed from front to back
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_POINT,
    KIND_RESTART
  } kind_t;

endpackage

[hw/rtl/scp_front.sv]
// ----------------------------------------------------------------------------
// scp_front: input acceptance, classification and work queue
// Takes input transfers, drops unused modes, queues work for the back end.
// ----------------------------------------------------------------------------
module scp_front #(
  parameter int CW = scp_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [scp_pkg::MODE_W-1:0]   in_mode,
  input  logic [scp_pkg::DELTA_W-1:0]  in_delta_ms,
  input  logic signed [CW-1:0]         in_point_x,
  input  logic signed [CW-1:0]         in_point_y,
  input  logic signed [CW-1:0]         in_point_z,
  input  logic                         q_deq,
  output logic                         q_valid,
  output scp_pkg::kind_t               q_kind,
  output logic [scp_pkg::DELTA_W-1:0]  q_delta,
  output logic signed [CW-1:0]         q_px,
  output logic signed [CW-1:0]         q_py,
  output logic signed [CW-1:0]         q_pz
);

  localparam int DEPTH = scp_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  scp_pkg::kind_t              kind_mem [DEPTH];
  logic [scp_pkg::DELTA_W-1:0] delta_mem [DEPTH];
  logic signed [CW-1:0]        px_mem [DEPTH];
  logic signed [CW-1:0]        py_mem [DEPTH];
  logic signed [CW-1:0]        pz_mem [DEPTH];

  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  scp_pkg::kind_t  kind;
  logic            keep;
  logic            enq, deq;

  // classify the mode; the unused code is accepted and dropped
  always_comb begin
    kind = scp_pkg::KIND_TICK;
    keep = 1'b1;
    unique case (in_mode)
      scp_pkg::MODE_TICK:    kind = scp_pkg::KIND_TICK;
      scp_pkg::MODE_POINT:   kind = scp_pkg::KIND_POINT;
      scp_pkg::MODE_RESTART: kind = scp_pkg::KIND_RESTART;
      default:               keep = 1'b0;
    endcase
  end

  assign in_full = (cnt_r == CNTW'(DEPTH));
  assign enq     = in_push && !in_full && keep;
  assign q_valid = (cnt_r != '0);
  assign deq     = q_deq && q_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (enq) begin
      kind_mem[wr_ptr_r]  <= kind;
      delta_mem[wr_ptr_r] <= in_delta_ms;
      px_mem[wr_ptr_r]    <= in_point_x;
      py_mem[wr_ptr_r]    <= in_point_y;
      pz_mem[wr_ptr_r]    <= in_point_z;
    end
  end

  assign q_kind  = kind_mem[rd_ptr_r];
  assign q_delta = delta_mem[rd_ptr_r];
  assign q_px    = px_mem[rd_ptr_r];
  assign q_py    = py_mem[rd_ptr_r];
  assign q_pz    = pz_mem[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (deq) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (enq && !deq) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (deq && !enq) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/scp_back.sv]
// ----------------------------------------------------------------------------
// scp_back: execution sequencer with center state and result register
// Ticks, restarts and point tests on one shared multiplier, an iterative
// square root and three bit-serial dividers.
// ----------------------------------------------------------------------------
module scp_back #(
  parameter int CW = scp_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_deq,
  input  scp_pkg::kind_t                q_kind,
  input  logic [scp_pkg::DELTA_W-1:0]   q_delta,
  input  logic signed [CW-1:0]          q_px,
  input  logic signed [CW-1:0]          q_py,
  input  logic signed [CW-1:0]          q_pz,
  input  logic [scp_pkg::RADIUS_W-1:0]  radius,
  input  logic signed [CW-1:0]          step_x,
  input  logic signed [CW-1:0]          step_y,
  input  logic signed [CW-1:0]          step_z,
  input  logic signed [CW-1:0]          start_x,
  input  logic signed [CW-1:0]          start_y,
  input  logic signed [CW-1:0]          start_z,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [CW-1:0]          out_x,
  output logic signed [CW-1:0]          out_y,
  output logic signed [CW-1:0]          out_z,
  output logic                          out_pushed,
  output logic                          out_degenerate
);

  localparam int RW  = scp_pkg::RADIUS_W;
  localparam int MW  = (CW + 2 > 32) ? CW + 2 : 32;
  localparam int PRW = 2 * MW;
  localparam int NW  = CW + 1 + RW;
  localparam int XW  = ((CW > RW) ? CW : RW) + 3;
  localparam int ITW = $clog2(MW);

  localparam logic signed [XW-1:0]  SAT_MAX = XW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [XW-1:0]  SAT_MIN = -SAT_MAX - 1;
  localparam logic signed [PRW-1:0] LIM_P   = PRW'({1'b1, {CW{1'b0}}});
  localparam logic signed [PRW-1:0] LIM_N   = -LIM_P;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_TMUL = 4'd1;
  localparam logic [3:0] ST_TADD = 4'd2;
  localparam logic [3:0] ST_DIFF = 4'd3;
  localparam logic [3:0] ST_SQ   = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_R2   = 4'd6;
  localparam logic [3:0] ST_CMP  = 4'd7;
  localparam logic [3:0] ST_SQRT = 4'd8;
  localparam logic [3:0] ST_NMUL = 4'd9;
  localparam logic [3:0] ST_NUM  = 4'd10;
  localparam logic [3:0] ST_DIV  = 4'd11;
  localparam logic [3:0] ST_SUM  = 4'd12;
  localparam logic [3:0] ST_EMIT = 4'd13;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = v;
    if (v > SAT_MAX) r = SAT_MAX;
    else if (v < SAT_MIN) r = SAT_MIN;
    return r[CW-1:0];
  endfunction

  logic [3:0]            state_r, state_nxt;
  logic [1:0]            ax_r;
  logic [ITW-1:0]        it_r;
  logic [scp_pkg::DELTA_W-1:0] delta_r;
  logic signed [CW-1:0]  p_r [3];
  logic signed [CW-1:0]  c_r [3];
  logic signed [CW:0]    d_r [3];
  logic signed [CW-1:0]  o_r [3];
  logic signed [CW-1:0]  stp [3];
  logic signed [CW-1:0]  qp  [3];
  logic [CW:0]           magd [3];
  logic signed [PRW-1:0] prod_r;
  logic [PRW-1:0]        acc_r;
  logic [PRW-1:0]        sq_r;
  logic [MW+1:0]         rem_r;
  logic [MW-1:0]         root_r;
  logic [MW-1:0]         drem_r [3];
  logic [RW-1:0]         nlo_r [3];
  logic [RW-1:0]         q_r [3];
  logic                  pushed_r, degen_r;
  logic                  ov_r;

  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PRW-1:0] pclamp;
  logic signed [CW+1:0]  pcl;
  logic [MW+3:0]         rem_sh, trial;
  logic                  load_out;

  assign stp[0] = step_x;
  assign stp[1] = step_y;
  assign stp[2] = step_z;
  assign qp[0]  = q_px;
  assign qp[1]  = q_py;
  assign qp[2]  = q_pz;

  // magnitudes of the differences
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      magd[i] = d_r[i][CW] ? (CW+1)'(-d_r[i]) : (CW+1)'(d_r[i]);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_TMUL: begin
        mul_a = MW'(stp[ax_r]);
        mul_b = MW'(delta_r);
      end
      ST_SQ: begin
        mul_a = MW'(magd[ax_r]);
        mul_b = MW'(magd[ax_r]);
      end
      ST_R2: begin
        mul_a = MW'(radius);
        mul_b = MW'(radius);
      end
      ST_NMUL: begin
        mul_a = MW'(magd[ax_r]);
        mul_b = MW'(radius);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // tick motion clamped to plus or minus one full coordinate range
  always_comb begin
    pclamp = prod_r;
    if (prod_r > LIM_P) pclamp = LIM_P;
    else if (prod_r < LIM_N) pclamp = LIM_N;
    pcl = pclamp[CW+1:0];
  end

  // square root digit step
  assign rem_sh = {rem_r, sq_r[PRW-1 -: 2]};
  assign trial  = (MW+4)'({root_r, 2'b01});

  assign q_deq     = (state_r == ST_IDLE) && q_valid;
  assign load_out  = (state_r == ST_EMIT) && (!ov_r || out_pop);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_kind)
            scp_pkg::KIND_TICK:  state_nxt = ST_TMUL;
            scp_pkg::KIND_POINT: state_nxt = ST_DIFF;
            default:             state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_TMUL: state_nxt = ST_TADD;
      ST_TADD: state_nxt = (ax_r == 2'd2) ? ST_IDLE : ST_TMUL;
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (ax_r == 2'd2) ? ST_R2 : ST_SQ;
      ST_R2:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (acc_r != '0 && acc_r < $unsigned(prod_r)) state_nxt = ST_SQRT;
        else state_nxt = ST_EMIT;
      end
      ST_SQRT: state_nxt = (it_r == ITW'(MW - 1)) ? ST_NMUL : ST_SQRT;
      ST_NMUL: state_nxt = ST_NUM;
      ST_NUM:  state_nxt = (ax_r == 2'd2) ? ST_DIV : ST_NMUL;
      ST_DIV:  state_nxt = (it_r == ITW'(RW - 1)) ? ST_SUM : ST_DIV;
      ST_SUM:  state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = load_out ? ST_IDLE : ST_EMIT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state, center and result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      for (int i = 0; i < 3; i++) c_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) ov_r <= 1'b1;
      else if (out_pop) ov_r <= 1'b0;
      if (q_deq && q_kind == scp_pkg::KIND_RESTART) begin
        c_r[0] <= start_x;
        c_r[1] <= start_y;
        c_r[2] <= start_z;
      end
      if (state_r == ST_TADD) begin
        c_r[ax_r] <= sat_c(XW'(c_r[ax_r]) + XW'(pcl));
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        ax_r    <= '0;
        delta_r <= q_delta;
        for (int i = 0; i < 3; i++) p_r[i] <= qp[i];
      end
      ST_TADD, ST_NUM: begin
        ax_r <= ax_r + 1'b1;
        it_r <= '0;
        if (state_r == ST_NUM) begin
          drem_r[ax_r] <= MW'(prod_r[NW-1:RW]);
          nlo_r[ax_r]  <= prod_r[RW-1:0];
        end
      end
      ST_DIFF: begin
        acc_r <= '0;
        for (int i = 0; i < 3; i++) begin
          d_r[i] <= (CW+1)'(p_r[i]) - (CW+1)'(c_r[i]);
        end
      end
      ST_ACC: begin
        acc_r <= acc_r + $unsigned(prod_r);
        ax_r  <= ax_r + 1'b1;
      end
      ST_CMP: begin
        sq_r     <= acc_r;
        rem_r    <= '0;
        root_r   <= '0;
        it_r     <= '0;
        ax_r     <= '0;
        pushed_r <= 1'b0;
        degen_r  <= (acc_r == '0);
        for (int i = 0; i < 3; i++) o_r[i] <= p_r[i];
      end
      ST_SQRT: begin
        sq_r <= sq_r << 2;
        it_r <= it_r + 1'b1;
        if (rem_sh >= trial) begin
          rem_r  <= (MW+2)'(rem_sh - trial);
          root_r <= {root_r[MW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[MW+1:0];
          root_r <= {root_r[MW-2:0], 1'b0};
        end
      end
      ST_DIV: begin
        it_r <= it_r + 1'b1;
        for (int i = 0; i < 3; i++) begin
          if ({drem_r[i], nlo_r[i][RW-1]} >= {1'b0, root_r}) begin
            drem_r[i] <= MW'({drem_r[i], nlo_r[i][RW-1]} - {1'b0, root_r});
            q_r[i]    <= {q_r[i][RW-2:0], 1'b1};
          end else begin
            drem_r[i] <= MW'({drem_r[i], nlo_r[i][RW-1]});
            q_r[i]    <= {q_r[i][RW-2:0], 1'b0};
          end
          nlo_r[i] <= nlo_r[i] << 1;
        end
      end
      ST_SUM: begin
        pushed_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          if (d_r[i][CW]) o_r[i] <= sat_c(XW'(c_r[i]) - XW'(q_r[i]));
          else            o_r[i] <= sat_c(XW'(c_r[i]) + XW'(q_r[i]));
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x          <= o_r[0];
      out_y          <= o_r[1];
      out_z          <= o_r[2];
      out_pushed     <= pushed_r;
      out_degenerate <= degen_r;
    end
  end

  assign out_empty = !ov_r;

endmodule

[hw/rtl/sphere_collision_projector_top.sv]
// Ticks and restarts use no square root or division; a point is passed through
// unless it lies inside the sphere and off its center, and then it is pushed out
// by the one-bit-a-cycle square root and the 31-step dividers.
// One item is executed at a time; a 2-entry queue takes input ahead of it.
// rst_n is synchronous, active low: clears the queue, the center, the result
// valid flag and sets the registers to radius 1.0 and zero vectors.
// ----------------------------------------------------------------------------
// sphere_collision_projector_top: moving sphere point collision projector
// Configuration registers, front end queue and back end execution.
// ----------------------------------------------------------------------------
module sphere_collision_projector_top #(
  parameter int COORD_WIDTH = scp_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = scp_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic [scp_pkg::MODE_W-1:0]             in_mode,
  input  logic [scp_pkg::DELTA_W-1:0]            in_delta_ms,
  input  logic signed [COORD_WIDTH-1:0]          in_point_x,
  input  logic signed [COORD_WIDTH-1:0]          in_point_y,
  input  logic signed [COORD_WIDTH-1:0]          in_point_z,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [COORD_WIDTH-1:0]          out_x,
  output logic signed [COORD_WIDTH-1:0]          out_y,
  output logic signed [COORD_WIDTH-1:0]          out_z,
  output logic                                   out_pushed,
  output logic                                   out_degenerate,
  input  logic                                   cfg_we,
  input  logic [scp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [((COORD_WIDTH > scp_pkg::RADIUS_W) ? COORD_WIDTH
                 : scp_pkg::RADIUS_W)-1:0]      cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int RW = scp_pkg::RADIUS_W;

  logic [RW-1:0]        radius_r;
  logic signed [CW-1:0] step_x_r, step_y_r, step_z_r;
  logic signed [CW-1:0] start_x_r, start_y_r, start_z_r;

  logic                        q_valid, q_deq;
  scp_pkg::kind_t              q_kind;
  logic [scp_pkg::DELTA_W-1:0] q_delta;
  logic signed [CW-1:0]        q_px, q_py, q_pz;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RW'(1) << FRAC_BITS;
      step_x_r  <= '0;
      step_y_r  <= '0;
      step_z_r  <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      start_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scp_pkg::REG_RADIUS:  radius_r  <= cfg_data[RW-1:0];
        scp_pkg::REG_STEP_X:  step_x_r  <= cfg_data[CW-1:0];
        scp_pkg::REG_STEP_Y:  step_y_r  <= cfg_data[CW-1:0];
        scp_pkg::REG_STEP_Z:  step_z_r  <= cfg_data[CW-1:0];
        scp_pkg::REG_START_X: start_x_r <= cfg_data[CW-1:0];
        scp_pkg::REG_START_Y: start_y_r <= cfg_data[CW-1:0];
        scp_pkg::REG_START_Z: start_z_r <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  scp_front #(.CW(CW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_mode     (in_mode),
    .in_delta_ms (in_delta_ms),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_point_z  (in_point_z),
    .q_deq       (q_deq),
    .q_valid     (q_valid),
    .q_kind      (q_kind),
    .q_delta     (q_delta),
    .q_px        (q_px),
    .q_py        (q_py),
    .q_pz        (q_pz)
  );

  scp_back #(.CW(CW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_deq          (q_deq),
    .q_kind         (q_kind),
    .q_delta        (q_delta),
    .q_px           (q_px),
    .q_py           (q_py),
    .q_pz           (q_pz),
    .radius         (radius_r),
    .step_x         (step_x_r),
    .step_y         (step_y_r),
    .step_z         (step_z_r),
    .start_x        (start_x_r),
    .start_y        (start_y_r),
    .start_z        (start_z_r),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_pushed     (out_pushed),
    .out_degenerate (out_degenerate)
  );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for sphere_collision_projector_top
// Directed and random tick, restart and point items under several register
// settings, with random idling on both queue sides and a long output stall.
// Each result is checked against an in-bench model of the moving sphere.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CW = 32;
  localparam int DW = 32;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          pushed;
    logic          degen;
  } point_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [scp_pkg::MODE_W-1:0] in_mode = scp_pkg::MODE_TICK;
  logic [scp_pkg::DELTA_W-1:0] in_delta_ms = '0;
  logic signed [CW-1:0] in_point_x = '0;
  logic signed [CW-1:0] in_point_y = '0;
  logic signed [CW-1:0] in_point_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [CW-1:0] out_x, out_y, out_z;
  logic out_pushed, out_degenerate;
  logic cfg_we = 1'b0;
  logic [scp_pkg::CFG_IDX_W-1:0] cfg_index = scp_pkg::REG_RADIUS;
  logic [DW-1:0] cfg_data = '0;

  // sphere model state
  longint radius_m;
  longint step_m[3];
  longint start_m[3];
  longint center_m[3];

  point_res_t expected_pts[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic hold_go = 1'b0;
  logic holding = 1'b0;
  int unsigned cycles = 0;

  sphere_collision_projector_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_mode(in_mode),
    .in_delta_ms(in_delta_ms), .in_point_x(in_point_x),
    .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_empty(out_empty), .out_pop(out_pop), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .out_pushed(out_pushed), .out_degenerate(out_degenerate),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint sat_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  // model: tick moves the center, restart reloads it, a point yields a result
  task automatic model_item(logic [scp_pkg::MODE_W-1:0] mode,
                            logic [scp_pkg::DELTA_W-1:0] dt,
                            logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic signed [CW-1:0] pz);
    longint p, lim;
    longint pt[3];
    longint d[3];
    longint o[3];
    logic [127:0] s, rr, n;
    logic [63:0] root_len, off;
    point_res_t r;
    lim = 64'sd1 << CW;
    if (mode == scp_pkg::MODE_TICK) begin
      for (int i = 0; i < 3; i++) begin
        p = step_m[i] * longint'(dt);
        if (p > lim) p = lim;
        if (p < -lim) p = -lim;
        center_m[i] = sat_coord(center_m[i] + p);
      end
    end else if (mode == scp_pkg::MODE_RESTART) begin
      center_m = start_m;
    end else if (mode == scp_pkg::MODE_POINT) begin
      pt[0] = px; pt[1] = py; pt[2] = pz;
      s = '0;
      for (int i = 0; i < 3; i++) begin
        d[i] = pt[i] - center_m[i];
        o[i] = pt[i];
        s += 128'(abs_l(d[i])) * 128'(abs_l(d[i]));
      end
      rr = 128'(radius_m) * 128'(radius_m);
      r.pushed = 1'b0;
      r.degen = (s == 0);
      if (s != 0 && s < rr) begin
        root_len = floor_sqrt(s);
        for (int i = 0; i < 3; i++) begin
          n = 128'(abs_l(d[i])) * 128'(radius_m);
          off = 64'(n / {64'd0, root_len});
          o[i] = sat_coord(d[i] < 0 ? center_m[i] - longint'(off)
                                    : center_m[i] + longint'(off));
        end
        r.pushed = 1'b1;
      end
      r.x = o[0][CW-1:0];
      r.y = o[1][CW-1:0];
      r.z = o[2][CW-1:0];
      expected_pts = {expected_pts, r};
    end
  endtask

  // one input transfer; in_push stays high until the next idle gap
  task automatic send_item(logic [scp_pkg::MODE_W-1:0] mode,
                           logic [scp_pkg::DELTA_W-1:0] dt,
                           logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_mode <= mode;
    in_delta_ms <= dt;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    do @(posedge clk); while (in_full);
    model_item(mode, dt, px, py, pz);
  endtask

  task automatic send_point(longint x, longint y, longint z);
    send_item(scp_pkg::MODE_POINT, '0, x[CW-1:0], y[CW-1:0], z[CW-1:0]);
  endtask

  // wait until every result is in, then let trailing ticks finish
  task automatic drain();
    in_push <= 1'b0;
    while (expected_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [scp_pkg::CFG_IDX_W-1:0] idx, logic [DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    unique case (idx)
      scp_pkg::REG_RADIUS:  radius_m = longint'(val[30:0]);
      scp_pkg::REG_STEP_X:  step_m[0] = longint'($signed(val));
      scp_pkg::REG_STEP_Y:  step_m[1] = longint'($signed(val));
      scp_pkg::REG_STEP_Z:  step_m[2] = longint'($signed(val));
      scp_pkg::REG_START_X: start_m[0] = longint'($signed(val));
      scp_pkg::REG_START_Y: start_m[1] = longint'($signed(val));
      scp_pkg::REG_START_Z: start_m[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [DW-1:0] rad, logic [DW-1:0] sx, logic [DW-1:0] sy,
                          logic [DW-1:0] sz, logic [DW-1:0] ax, logic [DW-1:0] ay,
                          logic [DW-1:0] az);
    drain();
    write_reg(scp_pkg::REG_RADIUS, rad);
    write_reg(scp_pkg::REG_STEP_X, sx);
    write_reg(scp_pkg::REG_STEP_Y, sy);
    write_reg(scp_pkg::REG_STEP_Z, sz);
    write_reg(scp_pkg::REG_START_X, ax);
    write_reg(scp_pkg::REG_START_Y, ay);
    write_reg(scp_pkg::REG_START_Z, az);
    cfg_we <= 1'b0;
  endtask

  // result side: check each transfer, then pick the next pop
  always @(posedge clk) begin
    point_res_t got, exp_r;
    if (rst_n && out_pop && !out_empty) begin
      got = '{out_x, out_y, out_z, out_pushed, out_degenerate};
      if (expected_pts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x=%h y=%h z=%h pushed=%b degen=%b",
                 $time, got.x, got.y, got.z, got.pushed, got.degen);
      end else begin
        exp_r = expected_pts.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch exp x=%h y=%h z=%h pushed=%b degen=%b",
                   $time, exp_r.x, exp_r.y, exp_r.z, exp_r.pushed, exp_r.degen);
          $display("%0t:          act x=%h y=%h z=%h pushed=%b degen=%b",
                   $time, got.x, got.y, got.z, got.pushed, got.degen);
        end
      end
    end
    out_pop <= !holding && ($urandom_range(99) >= recv_idle);
  end

  // long output stall on request
  always begin
    wait (hold_go);
    holding <= 1'b1;
    repeat (400) @(posedge clk);
    holding <= 1'b0;
    hold_go = 1'b0;
    @(posedge clk);
  end

  task automatic test_directed_points();
    set_regs(32'h0001_0000, '0, '0, '0, '0, '0, '0);
    send_point(0, 0, 0);                     // coincident with the center
    send_point(32'sh8000, 0, 0);             // inside, pushed
    send_point(-32'sh4000, 32'sh4000, -32'sh4000);
    send_point(32'sh1_0000, 0, 0);           // exactly on the surface
    send_point(32'sh2_0000, 5, -7);          // outside
    send_point(CMAX, CMIN, CMAX);
    send_point(CMIN, CMIN, CMIN);
    send_point(1, 0, 0);
    send_item(scp_pkg::MODE_UNUSED, 16'hFFFF, '1, '1, '1);   // ignored
    set_regs('0, '0, '0, '0, '0, '0, '0);    // zero radius
    send_point(0, 0, 0);
    send_point(1, 1, 1);
    set_regs(32'h7FFF_FFFF, '0, '0, '0, '0, '0, '0);  // largest radius
    send_point(CMAX, CMAX, CMAX);
    send_point(CMIN, 3, -3);
    send_point(-1, 0, 0);
  endtask

  task automatic test_motion();
    set_regs(32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h41,
             32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000);
    send_item(scp_pkg::MODE_TICK, 16'hFFFF, '0, '0, '0);  // saturates both ways
    send_point(CMAX, CMIN, 0);
    send_point(CMAX - 100, CMIN + 100, 32'sh1000);
    send_item(scp_pkg::MODE_TICK, 16'h0000, '0, '0, '0);
    send_item(scp_pkg::MODE_RESTART, '0, '0, '0, '0);
    send_point(CMAX - 32'sh8000, CMIN + 32'sh8000, -32'sh1_0000);
    send_item(scp_pkg::MODE_TICK, 16'd1, '0, '0, '0);
    send_point(CMAX, CMIN, 32'sh41);
  endtask

  task automatic test_backpressure();
    set_regs(32'h0003_0000, 32'h41, -32'sh41, 32'h0, '0, '0, '0);
    hold_go = 1'b1;
    repeat (30) send_point($signed(32'($urandom_range(65535))) - 32768, 100, -100);
  endtask

  task automatic test_random(int n);
    longint r, c[3];
    int m;
    for (int k = 0; k < n; k++) begin
      m = $urandom_range(99);
      r = radius_m * 2 + 2;
      if (r > 64'sd1 << 32) r = 64'sd1 << 32;
      for (int i = 0; i < 3; i++)
        c[i] = center_m[i] + longint'($urandom_range(32'(r))) - r / 2;
      if (m < 20) begin
        send_item(scp_pkg::MODE_TICK, ($urandom_range(9) == 0) ? 16'hFFFF
                  : scp_pkg::DELTA_W'($urandom_range(20)), $urandom, $urandom, $urandom);
      end else if (m < 28) begin
        send_item(scp_pkg::MODE_RESTART, scp_pkg::DELTA_W'($urandom),
                  $urandom, $urandom, $urandom);
      end else if (m < 31) begin
        send_item(scp_pkg::MODE_UNUSED, scp_pkg::DELTA_W'($urandom),
                  $urandom, $urandom, $urandom);
      end else if (m < 38) begin
        send_point(center_m[0], center_m[1], center_m[2]);
      end else if (m < 50) begin
        send_item(scp_pkg::MODE_POINT, scp_pkg::DELTA_W'($urandom),
                  $urandom, $urandom, $urandom);
      end else begin
        send_point(sat_coord(c[0]), sat_coord(c[1]), sat_coord(c[2]));
      end
    end
  endtask

  initial begin
    radius_m = 64'sd1 << 16;
    step_m = '{0, 0, 0};
    start_m = '{0, 0, 0};
    center_m = '{0, 0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_points();
    test_motion();
    test_backpressure();

    send_idle = 27;
    recv_idle = 88;
    set_regs(32'h0001_8000, 32'h41, -32'sh41, 32'h20, 32'sh10_0000, -32'sh5_0000, 0);
    test_random(266);
    send_idle = 88;
    recv_idle = 27;
    set_regs(32'h0000_0100, -32'sh3, 32'h7, 32'h0, -32'sh1, 32'h1, 32'h7FFF_0000);
    test_random(266);
    send_idle = 0;
    recv_idle = 0;
    set_regs(32'h0A00_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
             32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
    test_random(266);

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
